// ----- rtl/core/retry_queue_with_backoff_top_assert.svh -----
// Assertion macros for the retry queue block
`ifndef RETRY_QUEUE_WITH_BACKOFF_TOP_ASSERT_SVH
`define RETRY_QUEUE_WITH_BACKOFF_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset
`define RQB_ASSERT_IMP(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);
// Next-cycle implication checked outside reset
`define RQB_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);
`endif

// ----- rtl/core/rqb_pkg.sv -----
// ----------------------------------------------------------------------------
// rqb_pkg
// Shared constants and types of the retry queue with backoff.
// ----------------------------------------------------------------------------
package rqb_pkg;
   localparam int DEPTH = 8;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int MAX_LEN = 256;
   localparam logic [31:0] BACKOFF_CAP = 32'd60000;
   localparam logic [2:0] SHIFT_CAP = 3'd5;

   typedef enum logic [1:0] {
      ACT_ENQ = 2'd0, ACT_FETCH = 2'd1, ACT_REPORT = 2'd2, ACT_NONE = 2'd3
   } action_type;

   localparam logic [3:0] ST_QUEUED = 4'd0;
   localparam logic [3:0] ST_EVICT = 4'd1;
   localparam logic [3:0] ST_BADLEN = 4'd2;
   localparam logic [3:0] ST_FETCHED = 4'd3;
   localparam logic [3:0] ST_NONE = 4'd4;
   localparam logic [3:0] ST_SENT = 4'd5;
   localparam logic [3:0] ST_RETRY = 4'd6;
   localparam logic [3:0] ST_GIVEUP = 4'd7;
   localparam logic [3:0] ST_NOFLIGHT = 4'd8;
   localparam logic [3:0] ST_BUSY = 4'd9;

   localparam logic [1:0] REG_BASE = 2'd0;
   localparam logic [1:0] REG_JITTER = 2'd1;
   localparam logic [1:0] REG_MAXATT = 2'd2;

   // what the scan looks for
   typedef enum logic [1:0] {
      SCAN_FREE = 2'd0, SCAN_OLDEST = 2'd1, SCAN_READY = 2'd2
   } scan_type;

   // controller to datapath commands
   typedef struct packed {
      logic      latch;      // capture the request
      logic      scan_start; // reset the scan
      logic      scan_step;  // examine one slot
      scan_type  scan_mode;
      logic      do_enq;     // write new entry into found slot
      logic      do_fetch;   // move found slot to flight
      logic      do_retry;   // write flight back to found slot
      logic      do_sent;
      logic      do_fail;
      logic      do_evict;   // found slot is an eviction
      logic      calc;       // compute backoff
      logic      result;     // load the output register
      logic [3:0] status;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      action_type action;
      logic       len_bad;
      logic       flight_valid;
      logic       scan_done;
      logic       found;
      logic       give_up;
      logic       send_ok;
   } stat_type;
endpackage

// ----- rtl/core/retry_queue_with_backoff_top.sv -----
// A transaction is accepted only while the controller is idle. A none action
// returns to idle with no result; otherwise the result enters the output
// register straight after decode for a rejected length, a fetch while busy or
// a report with nothing in flight; after an apply step for a report that is
// sent or given up; after a scan of the 8-entry table, one slot per cycle, and
// an apply step for an enqueue or fetch. A full table needs a second pass for
// the oldest entry, and a retry takes a backoff step before its scan. A result
// still held by rsp_stall keeps the controller waiting before it loads the next one.
// ----------------------------------------------------------------------------
// retry_queue_with_backoff_top
// Retry queue with exponential backoff and jitter, controller plus datapath.
// ----------------------------------------------------------------------------
module retry_queue_with_backoff_top import rqb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_now_ms,
   input  logic [7:0]  req_payload_handle,
   input  logic        req_packet_kind,
   input  logic [15:0] req_packet_length,
   input  logic        req_send_ok,
   input  logic signed [15:0] req_jitter_offset,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_status,
   output logic [7:0]  rsp_out_handle,
   output logic        rsp_out_kind,
   output logic [7:0]  rsp_out_length,
   output logic [7:0]  rsp_out_attempts,
   output logic [3:0]  rsp_occupancy,
   output logic [31:0] rsp_sent_count,
   output logic [31:0] rsp_failed_count,
   output logic [31:0] rsp_dropped_count,
   output logic [31:0] rsp_queued_count,
   output logic [31:0] rsp_retry_count,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   cmd_type     cmd;
   stat_type    st;
   logic [15:0] base_ms;
   logic [14:0] span_ms;
   logic [7:0]  max_att;

   rqb_cfg u_cfg (
      .clock, .reset, .psel(csr_psel), .penable(csr_penable), .pwrite(csr_pwrite),
      .paddr(csr_paddr), .pwdata(csr_pwdata), .prdata(csr_prdata),
      .pready(csr_pready), .base_ms, .span_ms, .max_att
   );

   rqb_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .st, .cmd
   );

   rqb_dpath u_dpath (
      .clock, .reset, .cmd, .st, .req_action, .req_now_ms, .req_payload_handle,
      .req_packet_kind, .req_packet_length, .req_send_ok, .req_jitter_offset,
      .base_ms, .span_ms, .max_att, .rsp_status,
      .rsp_out_handle, .rsp_out_kind, .rsp_out_length, .rsp_out_attempts,
      .rsp_occupancy, .rsp_sent_count, .rsp_failed_count, .rsp_dropped_count,
      .rsp_queued_count, .rsp_retry_count
   );
endmodule

// ----- rtl/core/rqb_ctrl.sv -----
// ----------------------------------------------------------------------------
// rqb_ctrl
// Command sequencer: steps the slot scans and the update of one transaction.
// ----------------------------------------------------------------------------
`include "retry_queue_with_backoff_top_assert.svh"
module rqb_ctrl import rqb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  stat_type st,
   output cmd_type cmd
);
   typedef enum logic [2:0] {
      S_IDLE, S_DECODE, S_SCAN, S_SCAN2, S_CALC, S_APPLY, S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      evict_ff, evict_in;
   logic      busy;

   // accept while idle; the output register parts the two sides
   assign busy = (state_ff != S_IDLE);
   assign req_stall = busy;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      evict_in = evict_ff;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.scan_start = 1'b1;
            evict_in = 1'b0;
            state_in = S_SCAN;
            if (st.action == ACT_NONE) begin
               state_in = S_IDLE;
            end else if (st.action == ACT_ENQ) begin
               cmd.scan_mode = SCAN_FREE;
               if (st.len_bad) begin
                  cmd.status = ST_BADLEN;
                  state_in = S_OUT;
               end
            end else if (st.action == ACT_FETCH) begin
               cmd.scan_mode = SCAN_READY;
               if (st.flight_valid) begin
                  cmd.status = ST_BUSY;
                  state_in = S_OUT;
               end
            end else begin
               cmd.scan_mode = SCAN_FREE;
               if (!st.flight_valid) begin
                  cmd.status = ST_NOFLIGHT;
                  state_in = S_OUT;
               end else if (st.send_ok || st.give_up) begin
                  state_in = S_APPLY;
               end else begin
                  state_in = S_CALC;
               end
            end
         end
         S_CALC: begin
            cmd.calc = 1'b1;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            cmd.scan_mode = (st.action == ACT_FETCH) ? SCAN_READY : SCAN_FREE;
            if (st.scan_done) begin
               if (st.action != ACT_FETCH && !st.found) begin
                  // table full: second pass for the oldest entry
                  cmd.scan_start = 1'b1;
                  evict_in = 1'b1;
                  state_in = S_SCAN2;
               end else begin
                  state_in = S_APPLY;
               end
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_SCAN2: begin
            cmd.scan_mode = SCAN_OLDEST;
            if (st.scan_done) state_in = S_APPLY;
            else cmd.scan_step = 1'b1;
         end
         S_APPLY: begin
            state_in = S_OUT;
            unique case (st.action)
               ACT_ENQ: begin
                  cmd.do_enq = 1'b1;
                  cmd.do_evict = evict_ff;
                  cmd.status = evict_ff ? ST_EVICT : ST_QUEUED;
               end
               ACT_FETCH: begin
                  cmd.do_fetch = st.found;
                  cmd.status = st.found ? ST_FETCHED : ST_NONE;
               end
               default: begin
                  if (st.send_ok) begin
                     cmd.do_sent = 1'b1;
                     cmd.status = ST_SENT;
                  end else if (st.give_up) begin
                     cmd.do_fail = 1'b1;
                     cmd.status = ST_GIVEUP;
                  end else begin
                     cmd.do_retry = 1'b1;
                     cmd.do_evict = evict_ff;
                     cmd.status = ST_RETRY;
                  end
               end
            endcase
         end
         S_OUT: begin
            // wait for the output register to empty
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.result = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         evict_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         evict_ff <= evict_in;
      end
   end

   `RQB_ASSERT_IMP(a_no_accept_busy, clock, reset, busy, req_stall, "accept while busy")
   `RQB_ASSERT_NEXT(a_latch_decode, clock, reset, req_valid && !req_stall, state_ff == S_DECODE, "no decode")
   `RQB_ASSERT_IMP(a_result_slot, clock, reset, cmd.result, !rsp_valid_ff || !rsp_stall, "result overwrite")
endmodule

// ----- rtl/core/rqb_dpath.sv -----
// ----------------------------------------------------------------------------
// rqb_dpath
// Slot table, in-flight register, scan unit, backoff, counters and outputs.
// ----------------------------------------------------------------------------
module rqb_dpath import rqb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output stat_type    st,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_now_ms,
   input  logic [7:0]  req_payload_handle,
   input  logic        req_packet_kind,
   input  logic [15:0] req_packet_length,
   input  logic        req_send_ok,
   input  logic signed [15:0] req_jitter_offset,
   input  logic [15:0] base_ms,
   input  logic [14:0] span_ms,
   input  logic [7:0]  max_att,
   output logic [3:0]  rsp_status,
   output logic [7:0]  rsp_out_handle,
   output logic        rsp_out_kind,
   output logic [7:0]  rsp_out_length,
   output logic [7:0]  rsp_out_attempts,
   output logic [3:0]  rsp_occupancy,
   output logic [31:0] rsp_sent_count,
   output logic [31:0] rsp_failed_count,
   output logic [31:0] rsp_dropped_count,
   output logic [31:0] rsp_queued_count,
   output logic [31:0] rsp_retry_count
);
   typedef struct packed {
      logic [7:0]  handle;
      logic        kind;
      logic [7:0]  length;
      logic [7:0]  attempts;
      logic [31:0] first_time;
      logic [31:0] ready_time;
   } entry_type;

   // request capture
   logic [1:0]  act_ff;
   logic [31:0] now_ff;
   logic [7:0]  hnd_ff;
   logic        kind_ff;
   logic [15:0] len_ff;
   logic        ok_ff;
   logic signed [15:0] jit_ff;

   logic [DEPTH-1:0] valid_ff, valid_in;
   entry_type   slot_ff [DEPTH];
   logic        fl_valid_ff;
   entry_type   fl_ff;
   logic [3:0]  count_ff;
   logic [31:0] sent_ff, failed_ff, dropped_ff, queued_ff, retry_ff;
   logic [31:0] ready_time_ff;

   // result fields staged until the output register is free
   logic [3:0]  res_status_ff;
   logic [7:0]  res_handle_ff;
   logic        res_kind_ff;
   logic [7:0]  res_length_ff;
   logic [7:0]  res_att_ff;

   // scan unit
   logic [IDX_W:0]   ptr_ff;
   logic [IDX_W-1:0] best_ff;
   logic             found_ff;
   logic [IDX_W-1:0] pidx;
   logic             cand;
   logic [7:0]       att_inc;

   assign pidx = ptr_ff[IDX_W-1:0];
   assign att_inc = (fl_ff.attempts == 8'hFF) ? 8'hFF : fl_ff.attempts + 8'd1;

   always_comb begin
      cand = 1'b0;
      case (cmd.scan_mode)
         SCAN_FREE:   cand = !valid_ff[pidx] && !found_ff;
         SCAN_OLDEST: cand = valid_ff[pidx] && (!found_ff ||
            (slot_ff[pidx].first_time - slot_ff[best_ff].first_time) >= 32'h8000_0000);
         SCAN_READY:  cand = valid_ff[pidx] &&
            (slot_ff[pidx].ready_time == 32'd0 ||
             (now_ff - slot_ff[pidx].ready_time) < 32'h8000_0000) &&
            (!found_ff ||
             (slot_ff[pidx].first_time - slot_ff[best_ff].first_time) >= 32'h8000_0000);
         default:     cand = 1'b0;
      endcase
   end

   always_comb begin
      st.action = action_type'(act_ff);
      st.len_bad = (len_ff == 16'd0) || ({16'd0, len_ff} >= 32'(MAX_LEN));
      st.flight_valid = fl_valid_ff;
      // every slot examined
      st.scan_done = (ptr_ff == (IDX_W+1)'(DEPTH));
      st.found = found_ff;
      st.give_up = (att_inc >= max_att);
      st.send_ok = ok_ff;
   end

   // backoff, computed combinationally
   logic [2:0]  sh;
   logic [31:0] shifted, capped;
   logic signed [17:0] j, spn, r;
   always_comb begin
      sh = (att_inc - 8'd1 > 8'(SHIFT_CAP)) ? SHIFT_CAP : 3'(att_inc - 8'd1);
      shifted = {16'd0, base_ms} << sh;
      capped = (shifted > BACKOFF_CAP) ? BACKOFF_CAP : shifted;
      j = 18'(jit_ff);
      spn = {3'd0, span_ms};
      if (j > spn) j = spn;
      if (j < -spn) j = -spn;
      r = $signed({1'b0, capped[16:0]}) + j;
      if (r < 0) r = '0;
   end

   entry_type new_e;
   logic [IDX_W-1:0] tgt;
   always_comb begin
      tgt = best_ff;
      new_e = fl_ff;
      new_e.attempts = att_inc;
      new_e.ready_time = ready_time_ff;
      if (act_ff == ACT_ENQ) begin
         new_e.handle = hnd_ff;
         new_e.kind = kind_ff;
         new_e.length = len_ff[7:0];
         new_e.attempts = 8'd0;
         new_e.first_time = now_ff;
         new_e.ready_time = 32'd0;
      end
      valid_in = valid_ff;
      if (cmd.do_fetch) valid_in[tgt] = 1'b0;
      if (cmd.do_enq || cmd.do_retry) valid_in[tgt] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         act_ff <= req_action;
         now_ff <= req_now_ms;
         hnd_ff <= req_payload_handle;
         kind_ff <= req_packet_kind;
         len_ff <= req_packet_length;
         ok_ff <= req_send_ok;
         jit_ff <= req_jitter_offset;
      end
      if (cmd.calc) ready_time_ff <= now_ff + {14'd0, r};
      if (cmd.do_enq || cmd.do_retry) slot_ff[tgt] <= new_e;
      if (cmd.do_fetch) begin
         fl_ff <= slot_ff[tgt];
         slot_ff[tgt] <= '0;
      end
      if (cmd.do_sent || cmd.do_fail || cmd.do_retry) fl_ff <= '0;
      if (cmd.scan_step && cand) best_ff <= pidx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         fl_valid_ff <= 1'b0;
         count_ff <= '0;
         ptr_ff <= '0;
         found_ff <= 1'b0;
         {sent_ff, failed_ff, dropped_ff, queued_ff, retry_ff} <= '0;
         res_status_ff <= '0;
         res_handle_ff <= '0;
         res_kind_ff <= 1'b0;
         res_length_ff <= '0;
         res_att_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         if (cmd.scan_start) begin
            ptr_ff <= '0;
            found_ff <= 1'b0;
         end else if (cmd.scan_step) begin
            ptr_ff <= ptr_ff + 1'b1;
            if (cand) found_ff <= 1'b1;
         end
         if (cmd.do_fetch) begin
            fl_valid_ff <= 1'b1;
            count_ff <= count_ff - 4'd1;
         end
         if (cmd.do_sent || cmd.do_fail || cmd.do_retry) fl_valid_ff <= 1'b0;
         if (cmd.do_enq) queued_ff <= queued_ff + 32'd1;
         if (cmd.do_sent) sent_ff <= sent_ff + 32'd1;
         if (cmd.do_fail) failed_ff <= failed_ff + 32'd1;
         if (cmd.do_retry) retry_ff <= retry_ff + 32'd1;
         if (cmd.do_evict) dropped_ff <= dropped_ff + 32'd1;
         if ((cmd.do_enq || cmd.do_retry) && !cmd.do_evict) count_ff <= count_ff + 4'd1;
         // staged result; status latched at decode or apply
         if (cmd.status != ST_QUEUED || cmd.do_enq) begin
            res_status_ff <= cmd.status;
            res_handle_ff <= cmd.do_fetch ? slot_ff[tgt].handle : 8'd0;
            res_kind_ff <= cmd.do_fetch ? slot_ff[tgt].kind : 1'b0;
            res_length_ff <= cmd.do_fetch ? slot_ff[tgt].length : 8'd0;
            res_att_ff <= cmd.do_fetch ? slot_ff[tgt].attempts :
               (cmd.do_sent || cmd.do_fail || cmd.do_retry) ? att_inc : 8'd0;
         end
      end
   end

   // output register, loaded once the previous result has left
   always_ff @(posedge clock) begin
      if (cmd.result) begin
         rsp_status <= res_status_ff;
         rsp_out_handle <= res_handle_ff;
         rsp_out_kind <= res_kind_ff;
         rsp_out_length <= res_length_ff;
         rsp_out_attempts <= res_att_ff;
         rsp_occupancy <= count_ff;
         rsp_sent_count <= sent_ff;
         rsp_failed_count <= failed_ff;
         rsp_dropped_count <= dropped_ff;
         rsp_queued_count <= queued_ff;
         rsp_retry_count <= retry_ff;
      end
   end
endmodule

// ----- rtl/core/rqb_cfg.sv -----
// ----------------------------------------------------------------------------
// rqb_cfg
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
module rqb_cfg import rqb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic [15:0] base_ms,
   output logic [14:0] span_ms,
   output logic [7:0]  max_att
);
   logic [15:0] base_ff;
   logic [14:0] span_ff;
   logic [7:0]  max_ff;
   logic [1:0]  idx;

   assign pready = 1'b1;
   assign idx = paddr[3:2];
   assign base_ms = base_ff;
   assign span_ms = span_ff;
   assign max_att = max_ff;

   always_comb begin
      prdata = '0;
      unique case (idx)
         REG_BASE:   prdata = {16'd0, base_ff};
         REG_JITTER: prdata = {17'd0, span_ff};
         REG_MAXATT: prdata = {24'd0, max_ff};
         default:    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= 16'd1000;
         span_ff <= 15'd250;
         max_ff <= 8'd3;
      end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
         unique case (idx)
            REG_BASE:   base_ff <= pwdata[15:0];
            REG_JITTER: span_ff <= pwdata[14:0];
            REG_MAXATT: max_ff <= pwdata[7:0];
            default:    ;
         endcase
      end
   end
endmodule
